[rtl/core/gpio_pkg.sv]
// gpio port package: widths, pin mask, mode and register codes
package gpio_pkg;

  localparam int DATA_W    = 32;
  localparam int PINS      = 32;
  localparam int MODE_W    = 2;
  localparam int REG_SEL_W = 4;

  // pins at or above PINS never hold state
  localparam logic [DATA_W-1:0] PIN_MASK = DATA_W'((64'd1 << PINS) - 64'd1);

  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  localparam logic [REG_SEL_W-1:0] REG_DATA      = 4'd0;
  localparam logic [REG_SEL_W-1:0] REG_DATAOUT   = 4'd1;
  localparam logic [REG_SEL_W-1:0] REG_OUTEN_SET = 4'd2;
  localparam logic [REG_SEL_W-1:0] REG_OUTEN_CLR = 4'd3;
  localparam logic [REG_SEL_W-1:0] REG_INTEN_SET = 4'd4;
  localparam logic [REG_SEL_W-1:0] REG_INTEN_CLR = 4'd5;
  localparam logic [REG_SEL_W-1:0] REG_TYPE_SET  = 4'd6;
  localparam logic [REG_SEL_W-1:0] REG_TYPE_CLR  = 4'd7;
  localparam logic [REG_SEL_W-1:0] REG_POL_SET   = 4'd8;
  localparam logic [REG_SEL_W-1:0] REG_POL_CLR   = 4'd9;
  localparam logic [REG_SEL_W-1:0] REG_STATUS    = 4'd10;

  typedef logic [DATA_W-1:0] word_t;

endpackage

[rtl/core/gpio_if.sv]
// gpio port channel interfaces: request beats in, result beats out
interface gpio_req_if import gpio_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [REG_SEL_W-1:0] reg_sel;
  word_t                wdata;
  word_t                pins_in;

  modport source (output valid, mode, reg_sel, wdata, pins_in, input ready);
  modport sink   (input valid, mode, reg_sel, wdata, pins_in, output ready);
endinterface

interface gpio_rsp_if import gpio_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t rdata;
  word_t pad_out;
  word_t pad_oe;
  logic  irq;

  modport source (output valid, rdata, pad_out, pad_oe, irq, input ready);
  modport sink   (input valid, rdata, pad_out, pad_oe, irq, output ready);
endinterface

[rtl/core/gpio_port_with_pin_interrupts.sv]
// gpio port top level: register file, pin interrupt logic and result register
//
// A GPIO port of PINS pins behind a small register file. Each request beat is
// a register read, a register write or a pin-sample tick; each one produces
// exactly one result beat carrying the read value (zero on writes and ticks),
// the pad output data, the pad output enables and the interrupt request, all
// taken after the beat's own update. Output enable, interrupt enable, type
// (edge or level) and polarity each have write-one set and clear registers;
// status is write-one-to-clear. On a tick, an enabled level pin latches
// status while it sits at its polarity, an enabled edge pin when it has just
// moved to its polarity since the previous tick. irq is the OR of status.
// Timing: one beat per cycle while the result is not stalled. The register state is
// updated at the accepting edge and the result lands in a single output
// register at the same edge; a new beat is taken whenever that register is
// empty or is being emptied in the same cycle, so a stalled result blocks
// input for exactly as long as it waits.
module gpio_port_with_pin_interrupts
  import gpio_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  gpio_req_if.sink  in_ch,
  gpio_rsp_if.source out_ch
);

  // architectural state
  word_t out_data_r,   out_data_nxt;
  word_t out_enable_r, out_enable_nxt;
  word_t int_enable_r, int_enable_nxt;
  word_t int_edge_r,   int_edge_nxt;
  word_t int_pol_r,    int_pol_nxt;
  word_t int_status_r, int_status_nxt;
  word_t last_sample_r, last_sample_nxt;

  // result register
  logic  out_valid_r;
  word_t rdata_r, rdata_nxt;
  word_t pad_out_r;
  word_t pad_oe_r;
  logic  irq_r;

  logic  in_accept;
  word_t wmask;
  word_t pins_now;
  word_t at_pol;
  word_t changed;
  word_t hit;

  // accept whenever the result slot is free or draining this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign wmask    = in_ch.wdata & PIN_MASK;
  assign pins_now = in_ch.pins_in & PIN_MASK;

  // tick matching: level pins match at polarity, edge pins need a change too
  assign at_pol  = ~(pins_now ^ int_pol_r);
  assign changed = pins_now ^ last_sample_r;
  assign hit     = ((~int_edge_r & at_pol) | (int_edge_r & changed & at_pol))
                   & int_enable_r & PIN_MASK;

  // read mux, only seen on read beats
  always_comb begin
    rdata_nxt = '0;
    if (in_ch.mode == MODE_READ) begin
      case (in_ch.reg_sel) inside
        REG_DATA:                     rdata_nxt = pins_now;
        REG_DATAOUT:                  rdata_nxt = out_data_r;
        REG_OUTEN_SET, REG_OUTEN_CLR: rdata_nxt = out_enable_r;
        REG_INTEN_SET, REG_INTEN_CLR: rdata_nxt = int_enable_r;
        REG_TYPE_SET,  REG_TYPE_CLR:  rdata_nxt = int_edge_r;
        REG_POL_SET,   REG_POL_CLR:   rdata_nxt = int_pol_r;
        REG_STATUS:                   rdata_nxt = int_status_r;
        default:                      rdata_nxt = '0;
      endcase
    end
  end

  // state update for the accepted beat
  always_comb begin
    out_data_nxt    = out_data_r;
    out_enable_nxt  = out_enable_r;
    int_enable_nxt  = int_enable_r;
    int_edge_nxt    = int_edge_r;
    int_pol_nxt     = int_pol_r;
    int_status_nxt  = int_status_r;
    last_sample_nxt = last_sample_r;
    if (in_accept) begin
      if (in_ch.mode == MODE_WRITE) begin
        unique case (in_ch.reg_sel)
          REG_DATAOUT:   out_data_nxt   = wmask;
          REG_OUTEN_SET: out_enable_nxt = out_enable_r | wmask;
          REG_OUTEN_CLR: out_enable_nxt = out_enable_r & ~wmask;
          REG_INTEN_SET: int_enable_nxt = int_enable_r | wmask;
          REG_INTEN_CLR: int_enable_nxt = int_enable_r & ~wmask;
          REG_TYPE_SET:  int_edge_nxt   = int_edge_r | wmask;
          REG_TYPE_CLR:  int_edge_nxt   = int_edge_r & ~wmask;
          REG_POL_SET:   int_pol_nxt    = int_pol_r | wmask;
          REG_POL_CLR:   int_pol_nxt    = int_pol_r & ~wmask;
          REG_STATUS:    int_status_nxt = int_status_r & ~wmask;
          default:       ; // data register is read only, others unmapped
        endcase
      end else if (in_ch.mode == MODE_TICK) begin
        int_status_nxt  = int_status_r | hit;
        last_sample_nxt = pins_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_data_r    <= '0;
      out_enable_r  <= '0;
      int_enable_r  <= '0;
      int_edge_r    <= '0;
      int_pol_r     <= '0;
      int_status_r  <= '0;
      last_sample_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_data_r    <= out_data_nxt;
      out_enable_r  <= out_enable_nxt;
      int_enable_r  <= int_enable_nxt;
      int_edge_r    <= int_edge_nxt;
      int_pol_r     <= int_pol_nxt;
      int_status_r  <= int_status_nxt;
      last_sample_r <= last_sample_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload captures the post-update view of the port
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rdata_r   <= rdata_nxt;
      pad_out_r <= out_data_nxt;
      pad_oe_r  <= out_enable_nxt;
      irq_r     <= |int_status_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.rdata   = rdata_r;
  assign out_ch.pad_out = pad_out_r;
  assign out_ch.pad_oe  = pad_oe_r;
  assign out_ch.irq     = irq_r;

`ifndef SYNTH
  // a pending result always matches the live state, as no beat has followed
  a_irq_tracks_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (irq_r == (|int_status_r)))
    else $error("irq does not match status");

  a_pads_track_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pad_out_r == out_data_r && pad_oe_r == out_enable_r))
    else $error("pad result does not match state");

  // only reads return data
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_ch.mode != MODE_READ) |=> (rdata_r == '0))
    else $error("non-read beat returned data");

  // status bits are only ever raised by a tick
  a_status_set_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && in_ch.mode == MODE_TICK) |=>
      ((int_status_r & ~$past(int_status_r)) == '0))
    else $error("status set outside a tick");

  // nothing lives above the top pin
  a_unused_pins_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((out_data_r | out_enable_r | int_enable_r | int_edge_r | int_pol_r
      | int_status_r | last_sample_r) & ~PIN_MASK) == '0)
    else $error("state held above top pin");
`endif

endmodule

[tb/tb.sv]
// testbench for the gpio port: directed and random beats checked against a bit-level port model
module tb
  import gpio_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // mode three does nothing; register numbers above ten read as zero
  localparam logic [MODE_W-1:0]    MODE_NOP    = 2'd3;
  localparam logic [REG_SEL_W-1:0] REG_SEL_TOP = 4'd15;

  // generous run limit, far above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 31;
  localparam int TAIL_CYCLES = 4;

  typedef struct packed {
    word_t rdata;
    word_t pad_out;
    word_t pad_oe;
    logic  irq;
  } port_result_t;

  logic clk;
  logic rst_n;

  // no idling on either side while this is set
  logic steady;

  int mismatches;
  int cycles;

  gpio_req_if req_ch ();
  gpio_rsp_if rsp_ch ();

  gpio_port_with_pin_interrupts dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // port model state, mirrors the block's registers
  word_t mdl_out_data;
  word_t mdl_out_enable;
  word_t mdl_int_enable;
  word_t mdl_int_is_edge;
  word_t mdl_int_pol_high;
  word_t mdl_int_status;
  word_t mdl_last_sample;

  // results the port owes us, oldest first
  port_result_t port_results_q[$];

  // free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5ns clk = ~clk;

  // apply one accepted beat to the model and return the result it must produce
  function automatic port_result_t step_port_model(input logic [MODE_W-1:0] mode,
                                                   input logic [REG_SEL_W-1:0] sel,
                                                   input word_t wdata,
                                                   input word_t pins);
    port_result_t res;
    word_t        m;
    word_t        now;
    word_t        at_pol;
    word_t        moved;
    word_t        hit;
    res = '0;
    m   = wdata & PIN_MASK;
    if (mode == MODE_READ) begin
      // a set or clear register reads back the register the pair controls
      case (sel)
        REG_DATA:                     res.rdata = pins & PIN_MASK;
        REG_DATAOUT:                  res.rdata = mdl_out_data;
        REG_OUTEN_SET, REG_OUTEN_CLR: res.rdata = mdl_out_enable;
        REG_INTEN_SET, REG_INTEN_CLR: res.rdata = mdl_int_enable;
        REG_TYPE_SET, REG_TYPE_CLR:   res.rdata = mdl_int_is_edge;
        REG_POL_SET, REG_POL_CLR:     res.rdata = mdl_int_pol_high;
        REG_STATUS:                   res.rdata = mdl_int_status;
        default:                      res.rdata = '0;
      endcase
    end else if (mode == MODE_WRITE) begin
      // the data register is read only, so a write there falls to default
      case (sel)
        REG_DATAOUT:   mdl_out_data     = m;
        REG_OUTEN_SET: mdl_out_enable   = mdl_out_enable | m;
        REG_OUTEN_CLR: mdl_out_enable   = mdl_out_enable & ~m;
        REG_INTEN_SET: mdl_int_enable   = mdl_int_enable | m;
        REG_INTEN_CLR: mdl_int_enable   = mdl_int_enable & ~m;
        REG_TYPE_SET:  mdl_int_is_edge  = mdl_int_is_edge | m;
        REG_TYPE_CLR:  mdl_int_is_edge  = mdl_int_is_edge & ~m;
        REG_POL_SET:   mdl_int_pol_high = mdl_int_pol_high | m;
        REG_POL_CLR:   mdl_int_pol_high = mdl_int_pol_high & ~m;
        REG_STATUS:    mdl_int_status   = mdl_int_status & ~m;
        default:       ;
      endcase
    end else if (mode == MODE_TICK) begin
      // level pins match at their polarity, edge pins only on a move to it
      now    = pins & PIN_MASK;
      at_pol = ~(now ^ mdl_int_pol_high);
      moved  = now ^ mdl_last_sample;
      hit    = (~mdl_int_is_edge & at_pol) | (mdl_int_is_edge & moved & at_pol);
      mdl_int_status  = mdl_int_status | (hit & mdl_int_enable & PIN_MASK);
      mdl_last_sample = now;
    end
    res.pad_out = mdl_out_data;
    res.pad_oe  = mdl_out_enable;
    res.irq     = (mdl_int_status != '0);
    return res;
  endfunction

  // offer one beat, idling first at random, and log its result once accepted
  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [REG_SEL_W-1:0] sel,
                           input word_t wdata, input word_t pins);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= mode;
    req_ch.reg_sel <= sel;
    req_ch.wdata   <= wdata;
    req_ch.pins_in <= pins;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    port_results_q.push_back(step_port_model(mode, sel, wdata, pins));
  endtask

  // hold the sender off until every owed result beat has come back
  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (port_results_q.size() != 0) @(posedge clk);
  endtask

  // status reset value, data reads at both pin extremes, an unused register number
  task automatic test_reset_reads();
    send_beat(MODE_READ, REG_DATA, '0, '1);
    send_beat(MODE_READ, REG_DATA, '1, '0);
    send_beat(MODE_READ, REG_STATUS, '0, '1);
    send_beat(MODE_READ, REG_SEL_TOP, '1, '1);
  endtask

  // pad data and output enables, including a write to the read-only data register
  task automatic test_pad_outputs();
    send_beat(MODE_WRITE, REG_DATAOUT, '1, '0);
    send_beat(MODE_WRITE, REG_OUTEN_SET, '1, '0);
    send_beat(MODE_READ, REG_OUTEN_CLR, '0, '0);
    send_beat(MODE_WRITE, REG_OUTEN_CLR, 32'h0000_ffff, '1);
    send_beat(MODE_WRITE, REG_DATA, '1, '1);
    send_beat(MODE_WRITE, REG_DATAOUT, '0, '1);
  endtask

  // level interrupts at reset polarity (low), then write-one-to-clear status
  task automatic test_level_irq();
    send_beat(MODE_WRITE, REG_INTEN_SET, '1, '0);
    send_beat(MODE_TICK, REG_DATA, '0, '1);
    send_beat(MODE_TICK, REG_DATA, '0, '0);
    send_beat(MODE_READ, REG_STATUS, '0, '0);
    send_beat(MODE_WRITE, REG_STATUS, '1, '0);
  endtask

  // rising edges latch, a steady level does not; then upper pins back to level, all to low polarity
  task automatic test_edge_irq();
    send_beat(MODE_WRITE, REG_TYPE_SET, '1, '0);
    send_beat(MODE_WRITE, REG_POL_SET, '1, '0);
    send_beat(MODE_TICK, REG_DATA, '1, '0);
    send_beat(MODE_TICK, REG_DATA, '0, 32'ha5a5_a5a5);
    send_beat(MODE_READ, REG_STATUS, '0, '0);
    send_beat(MODE_WRITE, REG_TYPE_CLR, 32'hffff_0000, '0);
    send_beat(MODE_WRITE, REG_POL_CLR, '1, '1);
    send_beat(MODE_WRITE, REG_STATUS, '1, '0);
  endtask

  // mode three changes nothing; writes above register ten are dropped
  task automatic test_idle_mode();
    send_beat(MODE_NOP, REG_STATUS, '1, '1);
    send_beat(MODE_WRITE, REG_SEL_TOP, '1, '1);
  endtask

  // random traffic: ticks with toggling pins, set/clear writes and reads, some idle-mode noise
  task automatic test_random_traffic(input int beats);
    logic [MODE_W-1:0]    mode;
    logic [REG_SEL_W-1:0] sel;
    word_t                wdata;
    word_t                pins_now;
    int                   r;
    pins_now = $urandom();
    repeat (beats) begin
      r     = $urandom_range(0, 99);
      sel   = REG_DATA;
      wdata = $urandom();
      if (r < 32) begin
        mode = MODE_TICK;
        // small toggles give real edges; sometimes a whole new pin pattern
        if ($urandom_range(0, 3) == 0) pins_now = $urandom();
        else pins_now = pins_now ^ ($urandom() & $urandom() & $urandom());
      end else if (r < 64) begin
        mode = MODE_WRITE;
        case ($urandom_range(0, 9))
          0:       sel = REG_SEL_TOP - 4'($urandom_range(0, 4));
          1:       sel = REG_DATA;
          default: sel = 4'($urandom_range(REG_DATAOUT, REG_STATUS));
        endcase
        case ($urandom_range(0, 5))
          0:       wdata = '1;
          1:       wdata = '0;
          2:       wdata = $urandom() & $urandom();
          default: wdata = $urandom();
        endcase
      end else if (r < 95) begin
        mode     = MODE_READ;
        sel      = 4'($urandom_range(REG_DATA, REG_SEL_TOP));
        pins_now = $urandom();
      end else begin
        mode = MODE_NOP;
        sel  = 4'($urandom_range(REG_DATA, REG_SEL_TOP));
      end
      send_beat(mode, sel, wdata, pins_now);
    end
  endtask

  // receiver: stalls at random unless in the steady stretch
  always @(posedge clk) begin
    if (steady) rsp_ch.ready <= 1'b1;
    else        rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result checker: every result beat against the oldest owed result
  always @(posedge clk) begin
    port_result_t seen;
    port_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      seen.rdata   = rsp_ch.rdata;
      seen.pad_out = rsp_ch.pad_out;
      seen.pad_oe  = rsp_ch.pad_oe;
      seen.irq     = rsp_ch.irq;
      if (port_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: rdata=%h pad_out=%h pad_oe=%h irq=%b",
                   seen.rdata, seen.pad_out, seen.pad_oe, seen.irq);
      end else begin
        want = port_results_q.pop_front();
        if (seen.rdata !== want.rdata || seen.pad_out !== want.pad_out ||
            seen.pad_oe !== want.pad_oe || seen.irq !== want.irq) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected rdata=%h pad_out=%h pad_oe=%h irq=%b,",
                      " got rdata=%h pad_out=%h pad_oe=%h irq=%b"},
                     want.rdata, want.pad_out, want.pad_oe, want.irq,
                     seen.rdata, seen.pad_out, seen.pad_oe, seen.irq);
        end
      end
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // every input known from time zero, reset held before the tests begin
    rst_n          = 1'b0;
    steady         = 1'b0;
    mismatches     = 0;
    cycles         = 0;
    req_ch.valid   = 1'b0;
    req_ch.mode    = MODE_READ;
    req_ch.reg_sel = REG_DATA;
    req_ch.wdata   = '0;
    req_ch.pins_in = '0;
    rsp_ch.ready   = 1'b0;
    mdl_out_data     = '0;
    mdl_out_enable   = '0;
    mdl_int_enable   = '0;
    mdl_int_is_edge  = '0;
    mdl_int_pol_high = '0;
    mdl_int_status   = '0;
    mdl_last_sample  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_reads();
    test_pad_outputs();
    test_level_irq();
    test_edge_irq();
    test_idle_mode();

    test_random_traffic(400);
    // sender waits for the port to catch up fully before going on
    wait_results_drained();

    // long stretch with no idling on either side
    steady <= 1'b1;
    test_random_traffic(300);
    wait_results_drained();
    steady <= 1'b0;

    test_random_traffic(425);
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && port_results_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
